// ----- design/cfar_noise_floor_defines.svh -----
// assertion macros for the cfar noise floor modules
`ifndef CFAR_NOISE_FLOOR_DEFINES_SVH
`define CFAR_NOISE_FLOOR_DEFINES_SVH

// implication checked every cycle out of reset
`define CFARNF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define CFARNF_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ----- design/cfarnf_pkg.sv -----
// shared constants, types and codes for the cfar noise floor
package cfarnf_pkg;

    localparam int FRAME_BINS = 64;
    localparam int BIN_IDX_W  = $clog2(FRAME_BINS);
    localparam int EDGE_W     = $clog2(FRAME_BINS + 1);

    localparam int AMP_W   = 16;
    localparam int REF_W   = 6;
    localparam int GUARD_W = 4;
    localparam int BIAS_W  = 12;
    localparam int REF_MAX = 32;
    localparam int FRAC_W  = 8;

    // wide enough for cut + guard + ref + 1 before clipping
    localparam int POS_W = $clog2(FRAME_BINS + REF_MAX + (1 << GUARD_W) + 1);
    localparam int SUM_W = AMP_W + BIN_IDX_W;
    localparam int CNT_W = EDGE_W;
    localparam int LHS_W = AMP_W + CNT_W + FRAC_W;
    localparam int RHS_W = SUM_W + BIAS_W;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BIAS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_CELLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_CELLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q8     = 2'd2;

    localparam logic [REF_W-1:0]   REF_CELLS_RST   = 6'd8;
    localparam logic [GUARD_W-1:0] GUARD_CELLS_RST = 4'd2;
    localparam logic [BIAS_W-1:0]  BIAS_Q8_RST     = 12'd256;

    localparam logic [BIN_IDX_W-1:0] LAST_BIN = BIN_IDX_W'(FRAME_BINS - 1);

    typedef struct packed {
        logic [AMP_W-1:0]     amp;
        logic [BIN_IDX_W-1:0] idx;
        logic                 last;
    } t_bin_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_back_state;

endpackage

// ----- design/cfarnf_front.sv -----
// input side: takes bin beats, tags them with bin index and frame end
module cfarnf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [cfarnf_pkg::AMP_W-1:0] i_bin_amplitude,
    input  cfarnf_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output cfarnf_pkg::t_bin_item o_item
);

    logic [cfarnf_pkg::BIN_IDX_W-1:0] r_bin_idx;
    logic [cfarnf_pkg::BIN_IDX_W-1:0] n_bin_idx;
    logic                             bin_last;

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;
    assign bin_last   = (r_bin_idx == cfarnf_pkg::LAST_BIN);

    assign o_item.amp  = i_bin_amplitude;
    assign o_item.idx  = r_bin_idx;
    assign o_item.last = bin_last;

    always_comb begin
        n_bin_idx = r_bin_idx;
        if (o_push) begin
            n_bin_idx = bin_last ? '0 : r_bin_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_idx <= '0;
        end else begin
            r_bin_idx <= n_bin_idx;
        end
    end

endmodule

// ----- design/cfarnf_queue.sv -----
// short fifo of tagged bins between the input side and the detector
module cfarnf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cfarnf_pkg::t_bin_item i_item,
    input  logic                  i_pop,
    output cfarnf_pkg::t_bin_item o_item,
    output cfarnf_pkg::t_q_status o_status
);

    cfarnf_pkg::t_bin_item r_slots [cfarnf_pkg::QUEUE_DEPTH];
    logic [cfarnf_pkg::QUEUE_PTR_W:0] r_wr_ptr;
    logic [cfarnf_pkg::QUEUE_PTR_W:0] r_rd_ptr;
    logic [cfarnf_pkg::QUEUE_PTR_W:0] n_wr_ptr;
    logic [cfarnf_pkg::QUEUE_PTR_W:0] n_rd_ptr;

    // extra pointer bit tells full from empty
    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  =
        (r_wr_ptr[cfarnf_pkg::QUEUE_PTR_W] != r_rd_ptr[cfarnf_pkg::QUEUE_PTR_W]) &&
        (r_wr_ptr[cfarnf_pkg::QUEUE_PTR_W-1:0] == r_rd_ptr[cfarnf_pkg::QUEUE_PTR_W-1:0]);

    assign o_item = r_slots[r_rd_ptr[cfarnf_pkg::QUEUE_PTR_W-1:0]];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push && !o_status.full) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop && !o_status.empty) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_status.full) begin
            r_slots[r_wr_ptr[cfarnf_pkg::QUEUE_PTR_W-1:0]] <= i_item;
        end
    end

endmodule

// ----- design/cfarnf_back.sv -----
// detector: stores the frame with prefix sums, then tests each cell in turn
`include "cfar_noise_floor_defines.svh"

module cfarnf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfarnf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfarnf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  cfarnf_pkg::t_q_status      i_q_status,
    input  cfarnf_pkg::t_bin_item      i_q_item,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cfarnf_pkg::AMP_W-1:0] o_kept_amplitude,
    output logic                       o_detected,
    output logic                       o_frame_last
);

    cfarnf_pkg::t_back_state r_state;
    cfarnf_pkg::t_back_state n_state;

    logic [cfarnf_pkg::REF_W-1:0]   r_ref_cells;
    logic [cfarnf_pkg::GUARD_W-1:0] r_guard_cells;
    logic [cfarnf_pkg::BIAS_W-1:0]  r_bias_q8;

    // bin store and prefix sums; prefix entry k holds the sum of bins 0..k
    logic [cfarnf_pkg::AMP_W-1:0] bin_mem    [cfarnf_pkg::FRAME_BINS];
    logic [cfarnf_pkg::SUM_W-1:0] prefix_mem [cfarnf_pkg::FRAME_BINS];

    logic [cfarnf_pkg::SUM_W-1:0]     r_run;
    logic [cfarnf_pkg::SUM_W-1:0]     run_next;
    logic [cfarnf_pkg::BIN_IDX_W-1:0] r_cut;

    logic [cfarnf_pkg::REF_W-1:0] ref_sat;
    logic [cfarnf_pkg::POS_W-1:0] cut_x;
    logic [cfarnf_pkg::POS_W-1:0] g_x;
    logic [cfarnf_pkg::POS_W-1:0] gr_x;
    logic [cfarnf_pkg::POS_W-1:0] lo_r_raw;
    logic [cfarnf_pkg::POS_W-1:0] hi_r_raw;
    logic [cfarnf_pkg::EDGE_W-1:0] hi_l;
    logic [cfarnf_pkg::EDGE_W-1:0] lo_l;
    logic [cfarnf_pkg::EDGE_W-1:0] lo_r;
    logic [cfarnf_pkg::EDGE_W-1:0] hi_r;
    logic [cfarnf_pkg::EDGE_W-1:0] r_lo_r;
    logic [cfarnf_pkg::EDGE_W-1:0] r_hi_r;
    logic [cfarnf_pkg::CNT_W-1:0]  r_cnt;
    logic [cfarnf_pkg::CNT_W-1:0]  cnt_nz;

    logic                          rd_en;
    logic [cfarnf_pkg::EDGE_W-1:0] edge_a;
    logic [cfarnf_pkg::EDGE_W-1:0] edge_b;
    logic [cfarnf_pkg::SUM_W-1:0]  r_pa_raw;
    logic [cfarnf_pkg::SUM_W-1:0]  r_pb_raw;
    logic                          r_pa_zero;
    logic                          r_pb_zero;
    logic [cfarnf_pkg::SUM_W-1:0]  pa;
    logic [cfarnf_pkg::SUM_W-1:0]  pb;
    logic [cfarnf_pkg::AMP_W-1:0]  r_bin_rd;

    logic [cfarnf_pkg::SUM_W-1:0]  r_left;
    logic [cfarnf_pkg::SUM_W-1:0]  r_sum;
    logic [cfarnf_pkg::AMP_W-1:0]  r_cell;
    logic [cfarnf_pkg::LHS_W-1:0]  r_lhs;
    logic [cfarnf_pkg::RHS_W-1:0]  r_rhs;
    logic                          hit;
    logic                          out_load;

    logic                          r_out_valid;
    logic [cfarnf_pkg::AMP_W-1:0]  r_out_kept;
    logic                          r_out_det;
    logic                          r_out_last;

    // ---------------------------------------------------------------
    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_cells   <= cfarnf_pkg::REF_CELLS_RST;
            r_guard_cells <= cfarnf_pkg::GUARD_CELLS_RST;
            r_bias_q8     <= cfarnf_pkg::BIAS_Q8_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfarnf_pkg::CFG_REF_CELLS: begin
                    r_ref_cells <= i_cfg_data[cfarnf_pkg::REF_W-1:0];
                end
                cfarnf_pkg::CFG_GUARD_CELLS: begin
                    r_guard_cells <= i_cfg_data[cfarnf_pkg::GUARD_W-1:0];
                end
                cfarnf_pkg::CFG_BIAS_Q8: begin
                    r_bias_q8 <= i_cfg_data[cfarnf_pkg::BIAS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // window edges of the cell under test, clipped to the frame
    assign ref_sat  = (r_ref_cells > cfarnf_pkg::REF_W'(cfarnf_pkg::REF_MAX))
                    ? cfarnf_pkg::REF_W'(cfarnf_pkg::REF_MAX) : r_ref_cells;
    assign cut_x    = cfarnf_pkg::POS_W'(r_cut);
    assign g_x      = cfarnf_pkg::POS_W'(r_guard_cells);
    assign gr_x     = g_x + cfarnf_pkg::POS_W'(ref_sat);
    assign lo_r_raw = cut_x + g_x + 1'b1;
    assign hi_r_raw = lo_r_raw + cfarnf_pkg::POS_W'(ref_sat);

    assign hi_l = (cut_x >= g_x)  ? cfarnf_pkg::EDGE_W'(cut_x - g_x)  : '0;
    assign lo_l = (cut_x >= gr_x) ? cfarnf_pkg::EDGE_W'(cut_x - gr_x) : '0;
    assign lo_r = (lo_r_raw > cfarnf_pkg::POS_W'(cfarnf_pkg::FRAME_BINS))
                ? cfarnf_pkg::EDGE_W'(cfarnf_pkg::FRAME_BINS)
                : cfarnf_pkg::EDGE_W'(lo_r_raw);
    assign hi_r = (hi_r_raw > cfarnf_pkg::POS_W'(cfarnf_pkg::FRAME_BINS))
                ? cfarnf_pkg::EDGE_W'(cfarnf_pkg::FRAME_BINS)
                : cfarnf_pkg::EDGE_W'(hi_r_raw);

    assign cnt_nz = (r_cnt == '0) ? cfarnf_pkg::CNT_W'(1) : r_cnt;

    // prefix edge zero is the empty sum
    assign pa = r_pa_zero ? '0 : r_pa_raw;
    assign pb = r_pb_zero ? '0 : r_pb_raw;

    assign run_next = ((i_q_item.idx == '0) ? '0 : r_run)
                    + cfarnf_pkg::SUM_W'(i_q_item.amp);

    assign hit = cfarnf_pkg::CMP_W'(r_lhs) > cfarnf_pkg::CMP_W'(r_rhs);

    // ---------------------------------------------------------------
    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfarnf_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        rd_en    = 1'b0;
        edge_a   = hi_l;
        edge_b   = lo_l;
        out_load = 1'b0;
        unique case (r_state)
            cfarnf_pkg::ST_LOAD: begin
                o_q_pop = !i_q_status.empty;
                if (!i_q_status.empty && i_q_item.last) begin
                    n_state = cfarnf_pkg::ST_RD_LEFT;
                end
            end
            cfarnf_pkg::ST_RD_LEFT: begin
                rd_en   = 1'b1;
                n_state = cfarnf_pkg::ST_RD_RIGHT;
            end
            cfarnf_pkg::ST_RD_RIGHT: begin
                rd_en   = 1'b1;
                edge_a  = r_hi_r;
                edge_b  = r_lo_r;
                n_state = cfarnf_pkg::ST_SUM;
            end
            cfarnf_pkg::ST_SUM: begin
                n_state = cfarnf_pkg::ST_MUL;
            end
            cfarnf_pkg::ST_MUL: begin
                n_state = cfarnf_pkg::ST_OUT;
            end
            cfarnf_pkg::ST_OUT: begin
                out_load = !r_out_valid || !i_out_stall;
                if (out_load) begin
                    n_state = (r_cut == cfarnf_pkg::LAST_BIN)
                            ? cfarnf_pkg::ST_LOAD : cfarnf_pkg::ST_RD_LEFT;
                end
            end
            default: begin
                n_state = cfarnf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= '0;
        end else if (o_q_pop && i_q_item.last) begin
            r_cut <= '0;
        end else if (out_load) begin
            r_cut <= (r_cut == cfarnf_pkg::LAST_BIN) ? '0 : r_cut + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // frame memories
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            bin_mem[i_q_item.idx]    <= i_q_item.amp;
            prefix_mem[i_q_item.idx] <= run_next;
            r_run                    <= run_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pa_raw  <= prefix_mem[cfarnf_pkg::BIN_IDX_W'(edge_a - 1'b1)];
            r_pb_raw  <= prefix_mem[cfarnf_pkg::BIN_IDX_W'(edge_b - 1'b1)];
            r_pa_zero <= (edge_a == '0);
            r_pb_zero <= (edge_b == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cfarnf_pkg::ST_RD_LEFT) begin
            r_bin_rd <= bin_mem[r_cut];
        end
    end

    // ---------------------------------------------------------------
    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == cfarnf_pkg::ST_RD_LEFT) begin
            r_lo_r <= lo_r;
            r_hi_r <= hi_r;
            r_cnt  <= (hi_l - lo_l) + (hi_r - lo_r);
        end
        if (r_state == cfarnf_pkg::ST_RD_RIGHT) begin
            r_left <= pa - pb;
            r_cell <= r_bin_rd;
        end
        if (r_state == cfarnf_pkg::ST_SUM) begin
            r_sum <= r_left + (pa - pb);
        end
        if (r_state == cfarnf_pkg::ST_MUL) begin
            r_lhs <= (cfarnf_pkg::LHS_W'(r_cell) * cfarnf_pkg::LHS_W'(cnt_nz))
                     << cfarnf_pkg::FRAC_W;
            r_rhs <= r_sum * r_bias_q8;
        end
    end

    // ---------------------------------------------------------------
    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kept <= hit ? r_cell : '0;
            r_out_det  <= hit;
            r_out_last <= (r_cut == cfarnf_pkg::LAST_BIN);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kept_amplitude = r_out_kept;
    assign o_detected       = r_out_det;
    assign o_frame_last     = r_out_last;

    // ---------------------------------------------------------------
    `CFARNF_ASSERT_NEXT(a_frame_starts_emit, i_clk, i_rst_n,
        o_q_pop && i_q_item.last,
        r_state == cfarnf_pkg::ST_RD_LEFT && r_cut == '0,
        "full frame did not start emission at bin zero")
    `CFARNF_ASSERT_NEXT(a_last_returns_load, i_clk, i_rst_n,
        out_load && r_cut == cfarnf_pkg::LAST_BIN,
        r_state == cfarnf_pkg::ST_LOAD && o_frame_last,
        "final bin result did not close the frame")
    `CFARNF_ASSERT(a_detect_nonzero, i_clk, i_rst_n,
        (o_out_valid && o_detected) |-> (o_kept_amplitude != '0),
        "detected result carries a zero amplitude")
    `CFARNF_ASSERT(a_count_bound, i_clk, i_rst_n,
        (r_state == cfarnf_pkg::ST_SUM) |->
            (r_cnt <= cfarnf_pkg::CNT_W'(2 * cfarnf_pkg::REF_MAX)),
        "reference cell count beyond both windows")

endmodule

// ----- design/cfar_noise_floor.sv -----
// Cell-averaging CFAR over one frame of FRAME_BINS spectrum bins. Bin beats
// are taken one per cycle while the queue is not full into a four-entry
// queue and loaded into the frame store at one bin per cycle while bins are
// queued. Once the last bin of the frame is stored the detector tests every
// cell in bin order, each in turn: two reads of the two-port prefix-sum
// memory (left then right reference window), the window sum, the multiply,
// and the compare into the result register, which waits while the output
// stalls. While a frame is emitted the queue takes up to four beats of the
// next frame and then stalls the input until the emission ends. The frame
// store needs no clearing after reset. Configuration is sampled while a
// frame is emitted.
module cfar_noise_floor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cfarnf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cfarnf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [cfarnf_pkg::AMP_W-1:0]          i_bin_amplitude,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cfarnf_pkg::AMP_W-1:0]          o_kept_amplitude,
    output logic                                  o_detected,
    output logic                                  o_frame_last
);

    logic                  push;
    logic                  pop;
    cfarnf_pkg::t_bin_item push_item;
    cfarnf_pkg::t_bin_item head_item;
    cfarnf_pkg::t_q_status q_status;

    cfarnf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_bin_amplitude (i_bin_amplitude),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_item          (push_item)
    );

    cfarnf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    cfarnf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_q_status       (q_status),
        .i_q_item         (head_item),
        .o_q_pop          (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kept_amplitude (o_kept_amplitude),
        .o_detected       (o_detected),
        .o_frame_last     (o_frame_last)
    );

endmodule
